@@ sv/ptc_pkg.sv @@
// ptc_pkg: shared types, constants and a helper function for the
// pressure/temperature/humidity compensation core. No dependencies.
package ptc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned DIV_STAGES = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP        = 3'd0,
    CFG_PRESS_LO    = 3'd1,
    CFG_PRESS_HI    = 3'd2,
    CFG_PRESS_P9    = 3'd3,
    CFG_HUM         = 3'd4,
    CFG_HUM_PRESENT = 3'd5
  } cfg_idx_e;

  localparam logic signed [32:0] PRESS_TF_OFS  = 33'sd128000;
  localparam logic [20:0]        PRESS_BASE    = 21'd1048576;
  localparam logic [63:0]        PRESS_MUL     = 64'd3125;
  localparam logic [63:0]        PRESS_P1_BIAS = 64'h0000_8000_0000_0000;
  localparam logic [32:0]        SCALE_K       = 33'd8247038207;
  localparam logic [31:0]        TEMP_RND      = 32'd128;
  localparam logic [31:0]        HUM_TF_OFS    = 32'd76800;
  localparam logic [31:0]        HUM_RND       = 32'd16384;
  localparam logic [31:0]        HUM_H3_OFS    = 32'd32768;
  localparam logic [31:0]        HUM_G_OFS     = 32'd2097152;
  localparam logic [31:0]        HUM_F2_RND    = 32'd8192;
  localparam logic [31:0]        HUM_MAX       = 32'd419430400;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [24:0]        pressure_scaled;
    logic [16:0]        humidity_q22_10;
    logic               pressure_invalid;
  } out_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] press_p9;
    logic [63:0] hum;
    logic        hum_present;
  } calib_t;

  typedef struct packed {
    logic [31:0] tfine;
    logic [31:0] temp;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } temp_side_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        invalid;
    logic        neg;
  } div_side_t;

  // low 64 bits of a 64-bit pattern times a signed 17-bit value
  function automatic logic [63:0] mul64x16(input logic [63:0] a,
                                           input logic signed [16:0] b);
    logic signed [49:0] pl;
    logic [31:0]        ph;
    pl = $signed({1'b0, a[31:0]}) * b;
    ph = a[63:32] * 32'(b);
    return 64'(pl) + {ph, 32'h0};
  endfunction

endpackage

@@ sv/ptc_if.sv @@
// ptc_if: valid/ready stream interfaces for raw readings and results.
// Depends on ptc_pkg.
interface ptc_in_if;
  logic          valid;
  logic          ready;
  ptc_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptc_out_if;
  logic          valid;
  logic          ready;
  ptc_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/ptc_temp.sv @@
// ptc_temp: four-stage temperature pipeline producing t_fine and centi-degrees.
// Depends on ptc_pkg.
module ptc_temp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  ptc_pkg::in_t         in_i,
  input  logic [47:0]          calib_i,
  output logic                 vld_o,
  output ptc_pkg::temp_side_t  side_o
);
  import ptc_pkg::*;

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [31:0]        ta, dt, t5;
  logic [31:0]        a_d, dd_d, b0_d, tf_d;
  logic [31:0]        a_q, dd_q, a2_q, b0_q, tf_q;
  in_t                in_q [3];
  logic [3:0]         vld_q;
  temp_side_t         side_d, side_q;

  always_comb begin
    t1   = calib_i[15:0];
    t2   = $signed(calib_i[31:16]);
    t3   = $signed(calib_i[47:32]);
    ta   = {15'b0, in_i.raw_temperature[19:3]} - {15'b0, t1, 1'b0};
    a_d  = $signed(ta * 32'(t2)) >>> 11;
    dt   = {16'b0, in_i.raw_temperature[19:4]} - {16'b0, t1};
    dd_d = dt * dt;
    b0_d = ($signed(dd_q) >>> 12) * 32'(t3);
    tf_d = a2_q + 32'($signed(b0_q) >>> 14);
    t5   = tf_q * 32'd5 + TEMP_RND;
    side_d.temp         = $signed(t5) >>> 8;
    side_d.tfine        = tf_q;
    side_d.raw_pressure = in_q[2].raw_pressure;
    side_d.raw_humidity = in_q[2].raw_humidity;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= a_d;
      dd_q    <= dd_d;
      in_q[0] <= in_i;
      a2_q    <= a_q;
      b0_q    <= b0_d;
      in_q[1] <= in_q[0];
      tf_q    <= tf_d;
      in_q[2] <= in_q[1];
      side_q  <= side_d;
    end
  end

  assign vld_o  = vld_q[3];
  assign side_o = side_q;

endmodule

@@ sv/ptc_front.sv @@
// ptc_front: six-stage pressure numerator/divisor build and humidity pipeline.
// Depends on ptc_pkg.
module ptc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  ptc_pkg::temp_side_t  ts_i,
  input  ptc_pkg::calib_t      calib_i,
  output logic                 vld_o,
  output logic [63:0]          num_o,
  output logic [63:0]          den_o,
  output ptc_pkg::div_side_t   side_o
);
  import ptc_pkg::*;

  logic [15:0]        p1;
  logic signed [15:0] p2s, p3s, p4s, p5s, p6s, h2s;
  logic [7:0]         h1, h3;
  logic [11:0]        h4, h5;
  logic signed [7:0]  h6s;

  logic signed [32:0] v1s;
  logic signed [65:0] sq_full;
  logic signed [48:0] m5_d, m2_d;
  logic [31:0]        x, f1_d, m6_d, m3_d, g_d, gm_d, f2, hv_d, hs, hsq_d, ht, hw, hc;
  logic [20:0]        pp;
  logic [63:0]        v2a_d, v1a_d, v2_d, v1b_d, prod_d, n0_d, den_d, num_d;
  logic [63:0]        an, ad;
  div_side_t          side_d;

  logic [5:0]         vld_q;
  logic [63:0]        sq_q, v2a_q, v1a_q, v2_q, v1b_q, prod_q, n0_q, den_q, num_q;
  logic signed [48:0] m5_q, m2_q, m5b_q, m2b_q;
  logic [19:0]        adcp_q [3];
  logic [31:0]        temp_q [5];
  logic [31:0]        f1_q [3];
  logic [31:0]        m6_q, m3_q, g_q, gm_q, hv_q, hv5_q, hsq_q;
  logic [63:0]        num6_q, den6_q;
  div_side_t          side_q;

  always_comb begin
    p1  = calib_i.press_lo[15:0];
    p2s = $signed(calib_i.press_lo[31:16]);
    p3s = $signed(calib_i.press_lo[47:32]);
    p4s = $signed(calib_i.press_lo[63:48]);
    p5s = $signed(calib_i.press_hi[15:0]);
    p6s = $signed(calib_i.press_hi[31:16]);
    h1  = calib_i.hum[7:0];
    h2s = $signed(calib_i.hum[23:8]);
    h3  = calib_i.hum[31:24];
    h4  = calib_i.hum[43:32];
    h5  = calib_i.hum[55:44];
    h6s = $signed(calib_i.hum[63:56]);

    // pressure
    v1s     = $signed({ts_i.tfine[31], ts_i.tfine}) - PRESS_TF_OFS;
    sq_full = v1s * v1s;
    m5_d    = v1s * p5s;
    m2_d    = v1s * p2s;
    v2a_d   = mul64x16(sq_q, 17'(p6s));
    v1a_d   = mul64x16(sq_q, 17'(p3s));
    v2_d    = v2a_q + (64'(m5b_q) << 17) + (64'(p4s) << 35);
    v1b_d   = ($signed(v1a_q) >>> 8) + (64'(m2b_q) << 12);
    pp      = PRESS_BASE - {1'b0, adcp_q[2]};
    prod_d  = mul64x16(v1b_q + PRESS_P1_BIAS, $signed({1'b0, p1}));
    n0_d    = ({43'b0, pp} << 31) - v2_q;
    den_d   = $signed(prod_q) >>> 33;
    num_d   = n0_q * PRESS_MUL;
    an      = num_q[63] ? (64'd0 - num_q) : num_q;
    ad      = den_q[63] ? (64'd0 - den_q) : den_q;

    // humidity
    x     = ts_i.tfine - HUM_TF_OFS;
    f1_d  = $signed(({16'b0, ts_i.raw_humidity} << 14) - ({20'b0, h4} << 20)
                    - {20'b0, h5} * x + HUM_RND) >>> 15;
    m6_d  = x * 32'(h6s);
    m3_d  = x * {24'b0, h3};
    g_d   = 32'($signed(m6_q) >>> 10) * (32'($signed(m3_q) >>> 11) + HUM_H3_OFS);
    gm_d  = (32'($signed(g_q) >>> 10) + HUM_G_OFS) * 32'(h2s);
    f2    = $signed(gm_q + HUM_F2_RND) >>> 14;
    hv_d  = f1_q[2] * f2;
    hs    = $signed(hv_q) >>> 15;
    hsq_d = hs * hs;
    ht    = 32'($signed(hsq_q) >>> 7) * {24'b0, h1};
    hw    = hv5_q - 32'($signed(ht) >>> 4);
    if (hw[31]) begin
      hc = '0;
    end else if (hw > HUM_MAX) begin
      hc = HUM_MAX;
    end else begin
      hc = hw;
    end

    side_d.temp    = temp_q[4];
    side_d.hum     = calib_i.hum_present ? hc[28:12] : 17'd0;
    side_d.invalid = (den_q == 64'd0);
    side_d.neg     = num_q[63] ^ den_q[63];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q      <= sq_full[63:0];
      m5_q      <= m5_d;
      m2_q      <= m2_d;
      adcp_q[0] <= ts_i.raw_pressure;
      temp_q[0] <= ts_i.temp;
      f1_q[0]   <= f1_d;
      m6_q      <= m6_d;
      m3_q      <= m3_d;

      v2a_q     <= v2a_d;
      v1a_q     <= v1a_d;
      m5b_q     <= m5_q;
      m2b_q     <= m2_q;
      adcp_q[1] <= adcp_q[0];
      temp_q[1] <= temp_q[0];
      f1_q[1]   <= f1_q[0];
      g_q       <= g_d;

      v2_q      <= v2_d;
      v1b_q     <= v1b_d;
      adcp_q[2] <= adcp_q[1];
      temp_q[2] <= temp_q[1];
      f1_q[2]   <= f1_q[1];
      gm_q      <= gm_d;

      prod_q    <= prod_d;
      n0_q      <= n0_d;
      temp_q[3] <= temp_q[2];
      hv_q      <= hv_d;

      den_q     <= den_d;
      num_q     <= num_d;
      temp_q[4] <= temp_q[3];
      hv5_q     <= hv_q;
      hsq_q     <= hsq_d;

      num6_q    <= an;
      den6_q    <= ad;
      side_q    <= side_d;
    end
  end

  assign vld_o  = vld_q[5];
  assign num_o  = num6_q;
  assign den_o  = den6_q;
  assign side_o = side_q;

endmodule

@@ sv/ptc_div.sv @@
// ptc_div: unsigned 64/64 restoring divider, one quotient bit per stage.
// Depends on ptc_pkg.
module ptc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [63:0]         num_i,
  input  logic [63:0]         den_i,
  input  ptc_pkg::div_side_t  side_i,
  output logic                vld_o,
  output logic [63:0]         quo_o,
  output ptc_pkg::div_side_t  side_o
);
  import ptc_pkg::*;

  logic [DIV_STAGES-1:0] vld_q;
  logic [63:0]           rem_q  [DIV_STAGES-1];
  logic [63:0]           nq_q   [DIV_STAGES];
  logic [63:0]           den_q  [DIV_STAGES];
  div_side_t             side_q [DIV_STAGES];

  logic [63:0]           rem_s  [DIV_STAGES];
  logic [63:0]           nq_s   [DIV_STAGES];
  logic [63:0]           den_s  [DIV_STAGES];
  div_side_t             side_s [DIV_STAGES];
  logic [63:0]           rem_d  [DIV_STAGES];
  logic [63:0]           nq_d   [DIV_STAGES];
  logic [64:0]           trial  [DIV_STAGES];
  logic                  ge     [DIV_STAGES];

  always_comb begin
    rem_s[0]  = '0;
    nq_s[0]   = num_i;
    den_s[0]  = den_i;
    side_s[0] = side_i;
    for (int k = 1; k < DIV_STAGES; k++) begin
      rem_s[k]  = rem_q[k-1];
      nq_s[k]   = nq_q[k-1];
      den_s[k]  = den_q[k-1];
      side_s[k] = side_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      trial[k] = {rem_s[k], nq_s[k][63]};
      ge[k]    = (trial[k] >= {1'b0, den_s[k]});
      rem_d[k] = ge[k] ? 64'(trial[k] - {1'b0, den_s[k]}) : trial[k][63:0];
      nq_d[k]  = {nq_s[k][62:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        nq_q[k]   <= nq_d[k];
        den_q[k]  <= den_s[k];
        side_q[k] <= side_s[k];
      end
      for (int k = 0; k < DIV_STAGES - 1; k++) begin
        rem_q[k] <= rem_d[k];
      end
    end
  end

  assign vld_o  = vld_q[DIV_STAGES-1];
  assign quo_o  = nq_q[DIV_STAGES-1];
  assign side_o = side_q[DIV_STAGES-1];

endmodule

@@ sv/ptc_back.sv @@
// ptc_back: seven-stage pressure post-correction, mmHg-style scaling and
// output register. Depends on ptc_pkg.
module ptc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [63:0]         quo_i,
  input  ptc_pkg::div_side_t  side_i,
  input  ptc_pkg::calib_t     calib_i,
  output logic                vld_o,
  output ptc_pkg::out_t       res_o
);
  import ptc_pkg::*;

  logic signed [15:0] p7s, p8s, p9s;
  logic [63:0]        q_d, s, ll_d, m8_d, ss_d, v2p_d, t_d, psum, p64;
  logic [31:0]        cr_d, pq_d;
  logic [48:0]        hi_d, lo_d;
  logic [49:0]        scl;
  out_t               res_d;

  logic [6:0]         vld_q;
  div_side_t          side_q [6];
  logic [63:0]        q_q [4];
  logic [63:0]        ll_q, m8_q, ss_q, v2p_q [2], t_q;
  logic [31:0]        cr_q, pq_q, pq6_q;
  logic [48:0]        hi_q, lo_q;
  out_t               res_q;

  always_comb begin
    p7s   = $signed(calib_i.press_hi[47:32]);
    p8s   = $signed(calib_i.press_hi[63:48]);
    p9s   = $signed(calib_i.press_p9);

    q_d   = side_i.neg ? (64'd0 - quo_i) : quo_i;
    s     = $signed(q_q[0]) >>> 13;
    ll_d  = s[31:0] * s[31:0];
    cr_d  = s[63:32] * s[31:0];
    m8_d  = mul64x16(q_q[0], 17'(p8s));
    ss_d  = ll_q + {cr_q[30:0], 33'b0};
    v2p_d = $signed(m8_q) >>> 19;
    t_d   = mul64x16(ss_q, 17'(p9s));
    psum  = q_q[3] + 64'($signed(t_q) >>> 25) + v2p_q[1];
    p64   = ($signed(psum) >>> 8) + (64'(p7s) << 4);
    pq_d  = side_q[3].invalid ? 32'd0 : p64[31:0];
    hi_d  = pq_q[31:16] * SCALE_K;
    lo_d  = pq_q[15:0] * SCALE_K;
    scl   = {1'b0, hi_q} + {17'b0, lo_q[48:16]};

    res_d.temperature_centi = $signed(side_q[5].temp);
    res_d.pressure_q24_8    = pq6_q;
    res_d.pressure_scaled   = scl[48:24];
    res_d.humidity_q22_10   = side_q[5].hum;
    res_d.pressure_invalid  = side_q[5].invalid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < 6; k++) begin
        side_q[k] <= side_q[k-1];
      end
      q_q[0]   <= q_d;
      q_q[1]   <= q_q[0];
      q_q[2]   <= q_q[1];
      q_q[3]   <= q_q[2];
      ll_q     <= ll_d;
      cr_q     <= cr_d;
      m8_q     <= m8_d;
      ss_q     <= ss_d;
      v2p_q[0] <= v2p_d;
      v2p_q[1] <= v2p_q[0];
      t_q      <= t_d;
      pq_q     <= pq_d;
      hi_q     <= hi_d;
      lo_q     <= lo_d;
      pq6_q    <= pq_q;
      res_q    <= res_d;
    end
  end

  assign vld_o = vld_q[6];
  assign res_o = res_q;

endmodule

@@ sv/pressure_temp_humidity_compensation_core.sv @@
// pressure_temp_humidity_compensation_core: top level of the integer sensor
// compensation pipeline. Depends on ptc_pkg, ptc_if, ptc_temp, ptc_front,
// ptc_div and ptc_back.
//
// Usage:
//  raw_i carries one raw reading per transaction (temperature, pressure and
//  humidity codes); comp_o returns one compensated result per reading, in
//  order. Calibration is loaded through cfg_we_i/cfg_idx_i/cfg_data_i while
//  the pipeline is empty; unused register indexes are ignored.
//  A result passes 81 register stages before it shows on comp_o.valid:
//  4 of temperature, 6 of pressure setup and humidity, 64 of the pressure
//  divider (one quotient bit per stage) and 7 of pressure correction and
//  scaling, the last being the output register.
//  One reading per cycle unless comp_o stalls; all stages advance together.
//  When comp_o is stalled with a result held, raw_i.ready drops and the
//  whole pipeline freezes with its contents intact; a bubble at the output
//  register lets the pipeline advance even with comp_o.ready low.
//  Reset clears all valid bits and the calibration registers to zero.
module pressure_temp_humidity_compensation_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ptc_in_if.sink                           raw_i,
  ptc_out_if.source                        comp_o,
  input  logic                             cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ptc_pkg::*;

  calib_t     calib_d, calib_q;
  logic       en;
  logic       t_vld, f_vld, d_vld, out_vld;
  temp_side_t t_side;
  logic [63:0] f_num, f_den, d_quo;
  div_side_t  f_side, d_side;
  out_t       res;

  always_comb begin
    calib_d = calib_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TEMP:        calib_d.temp        = cfg_data_i[47:0];
        CFG_PRESS_LO:    calib_d.press_lo    = cfg_data_i;
        CFG_PRESS_HI:    calib_d.press_hi    = cfg_data_i;
        CFG_PRESS_P9:    calib_d.press_p9    = cfg_data_i[15:0];
        CFG_HUM:         calib_d.hum         = cfg_data_i;
        CFG_HUM_PRESENT: calib_d.hum_present = cfg_data_i[0];
        default:         calib_d             = calib_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q <= '0;
    end else begin
      calib_q <= calib_d;
    end
  end

  assign en          = !out_vld || comp_o.ready;
  assign raw_i.ready = en;

  ptc_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (raw_i.valid),
    .in_i    (raw_i.data),
    .calib_i (calib_q.temp),
    .vld_o   (t_vld),
    .side_o  (t_side)
  );

  ptc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (t_vld),
    .ts_i    (t_side),
    .calib_i (calib_q),
    .vld_o   (f_vld),
    .num_o   (f_num),
    .den_o   (f_den),
    .side_o  (f_side)
  );

  ptc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (f_vld),
    .num_i   (f_num),
    .den_i   (f_den),
    .side_i  (f_side),
    .vld_o   (d_vld),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  ptc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (d_vld),
    .quo_i   (d_quo),
    .side_i  (d_side),
    .calib_i (calib_q),
    .vld_o   (out_vld),
    .res_o   (res)
  );

  assign comp_o.valid = out_vld;
  assign comp_o.data  = res;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_o.valid && comp_o.data.pressure_invalid |->
      comp_o.data.pressure_q24_8 == 32'd0 && comp_o.data.pressure_scaled == 25'd0)
    else $error("invalid pressure result is not zero");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_o.valid |-> comp_o.data.humidity_q22_10 <= 17'd102400)
    else $error("humidity above clamp");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(d_vld) && $stable(f_vld) && $stable(t_vld))
    else $error("pipeline advanced while stalled");

endmodule
